// File: hw/rtl/mono_column_to_nibble_pixel_packer_top_macros.svh
// Assertion macros for the column to nibble pixel packer
`ifndef MONO_COLUMN_TO_NIBBLE_PIXEL_PACKER_TOP_MACROS_SVH
`define MONO_COLUMN_TO_NIBBLE_PIXEL_PACKER_TOP_MACROS_SVH

// check a condition in the same cycle
`define CNP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cnp assertion failed");

// check a condition in the next cycle
`define CNP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cnp assertion failed");

`endif

// File: hw/rtl/cnp_pkg.sv
// Shared types and constants of the column to nibble pixel packer
package cnp_pkg;

   localparam int ADDR_W      = 11;
   localparam int DATA_W      = 6;
   localparam int PIXEL_W     = 8;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD_W   = RSP_TDATA_W - ADDR_W - DATA_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int ROW_LAST    = 7;

   localparam logic [1:0] LEVEL_ON  = 2'b11;
   localparam logic [1:0] LEVEL_OFF = 2'b00;

   typedef struct packed {
      logic [PIXEL_W-1:0] odd_bits;
      logic [PIXEL_W-1:0] even_bits;
      logic [ADDR_W-1:0]  base_addr;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: hw/rtl/cnp_front.sv
// Front end: tracks frame position, buffers even columns, queues odd-column work
module cnp_front #(
   parameter int PANEL_COLUMNS = 128,
   parameter int PANEL_ROWS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cnp_pkg::PIXEL_W-1:0]   req_tdata,
   input  logic                          req_tuser,
   input  cnp_pkg::qstat_type            qstat,
   output logic                          push,
   output cnp_pkg::entry_type            push_entry
);

   localparam int BYTES_PER_COLUMN = (PANEL_ROWS + 7) / 8;
   localparam int SLOT_W = (BYTES_PER_COLUMN > 1) ? $clog2(BYTES_PER_COLUMN) : 1;
   localparam int COL_W = $clog2(PANEL_COLUMNS + 1);
   localparam int SLOT_SPAN = 8 * (PANEL_COLUMNS / 2);

   logic [COL_W-1:0]            col_ff, col_in, eff_col;
   logic [SLOT_W-1:0]           slot_ff, slot_in, eff_slot;
   logic [cnp_pkg::PIXEL_W-1:0] even_ff [BYTES_PER_COLUMN];
   logic [cnp_pkg::PIXEL_W-1:0] even_in [BYTES_PER_COLUMN];
   logic                        accept, live, last_slot, wr_even;
   logic [31:0]                 base_full;

   always_comb begin
      req_tready = !qstat.full;
      eff_col    = req_tuser ? '0 : col_ff;
      eff_slot   = req_tuser ? '0 : slot_ff;
      live       = (eff_col != COL_W'(PANEL_COLUMNS));
      accept     = req_tvalid && req_tready;
      last_slot  = (eff_slot == SLOT_W'(BYTES_PER_COLUMN - 1));
      col_in     = col_ff;
      slot_in    = slot_ff;
      if (accept) begin
         col_in  = eff_col;
         slot_in = eff_slot;
         if (live) begin
            slot_in = last_slot ? '0 : eff_slot + SLOT_W'(1);
            col_in  = last_slot ? eff_col + COL_W'(1) : eff_col;
         end
      end
      wr_even = accept && live && !eff_col[0];
      push    = accept && live && eff_col[0];
      for (int i = 0; i < BYTES_PER_COLUMN; i++) begin
         even_in[i] = even_ff[i];
      end
      if (wr_even) begin
         even_in[eff_slot] = req_tdata;
      end
      base_full = 32'(eff_slot) * 32'(SLOT_SPAN) + 32'(eff_col >> 1);
      push_entry.odd_bits  = req_tdata;
      push_entry.even_bits = even_ff[eff_slot];
      push_entry.base_addr = base_full[cnp_pkg::ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         slot_ff <= '0;
         for (int i = 0; i < BYTES_PER_COLUMN; i++) begin
            even_ff[i] <= '0;
         end
      end else begin
         col_ff  <= col_in;
         slot_ff <= slot_in;
         for (int i = 0; i < BYTES_PER_COLUMN; i++) begin
            even_ff[i] <= even_in[i];
         end
      end
   end

endmodule

// File: hw/rtl/cnp_queue.sv
// Work queue between front and back end
module cnp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cnp_pkg::entry_type push_entry,
   input  logic               pop,
   output cnp_pkg::entry_type head_entry,
   output cnp_pkg::qstat_type qstat
);

   cnp_pkg::entry_type          mem_ff [cnp_pkg::QUEUE_DEPTH];
   logic [cnp_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [cnp_pkg::QPTR_W:0]    count_ff, count_in;
   logic                        do_push, do_pop;

   always_comb begin
      qstat.full  = (count_ff == (cnp_pkg::QPTR_W + 1)'(cnp_pkg::QUEUE_DEPTH));
      qstat.empty = (count_ff == '0);
      do_push     = push && !qstat.full;
      do_pop      = pop && !qstat.empty;
      wr_ptr_in   = do_push ? wr_ptr_ff + cnp_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in   = do_pop ? rd_ptr_ff + cnp_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in    = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (cnp_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (cnp_pkg::QPTR_W + 1)'(1);
      end
      head_entry = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/cnp_back.sv
// Back end: expands one queued column pair byte into eight display writes
module cnp_back #(
   parameter int ROW_STRIDE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cnp_pkg::qstat_type          qstat,
   input  cnp_pkg::entry_type          head_entry,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cnp_pkg::ADDR_W-1:0]  rsp_addr,
   output logic [cnp_pkg::DATA_W-1:0]  rsp_data,
   output logic                        rsp_tlast
);

   localparam logic [cnp_pkg::ADDR_W-1:0] STRIDE = cnp_pkg::ADDR_W'(ROW_STRIDE);

   logic                        busy_ff, busy_in;
   logic [2:0]                  row_ff, row_in;
   logic [cnp_pkg::PIXEL_W-1:0] odd_ff, odd_in, even_ff, even_in;
   logic [cnp_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic                        valid_ff, valid_in;
   logic [cnp_pkg::ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [cnp_pkg::DATA_W-1:0]  out_data_ff, out_data_in;
   logic                        out_last_ff, out_last_in;
   logic                        advance, row_done;

   always_comb begin
      advance     = busy_ff && (!valid_ff || rsp_tready);
      row_done    = (row_ff == 3'(cnp_pkg::ROW_LAST));
      pop         = !qstat.empty && (!busy_ff || (advance && row_done));
      busy_in     = busy_ff;
      row_in      = row_ff;
      odd_in      = odd_ff;
      even_in     = even_ff;
      addr_in     = addr_ff;
      valid_in    = valid_ff && !rsp_tready;
      out_addr_in = out_addr_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      if (advance) begin
         valid_in    = 1'b1;
         out_addr_in = addr_ff;
         out_data_in = {odd_ff[cnp_pkg::PIXEL_W-1] ? cnp_pkg::LEVEL_ON : cnp_pkg::LEVEL_OFF,
                        cnp_pkg::LEVEL_OFF,
                        even_ff[cnp_pkg::PIXEL_W-1] ? cnp_pkg::LEVEL_ON : cnp_pkg::LEVEL_OFF};
         out_last_in = row_done;
         odd_in      = odd_ff << 1;
         even_in     = even_ff << 1;
         addr_in     = addr_ff + STRIDE;
         row_in      = row_ff + 3'(1);
         busy_in     = !row_done;
      end
      if (pop) begin
         busy_in = 1'b1;
         row_in  = '0;
         odd_in  = head_entry.odd_bits;
         even_in = head_entry.even_bits;
         addr_in = head_entry.base_addr;
      end
      rsp_tvalid = valid_ff;
      rsp_addr   = out_addr_ff;
      rsp_data   = out_data_ff;
      rsp_tlast  = out_last_ff;
   end

   always_ff @(posedge clock) begin
      odd_ff      <= odd_in;
      even_ff     <= even_in;
      addr_ff     <= addr_in;
      row_ff      <= row_in;
      out_addr_ff <= out_addr_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: hw/rtl/mono_column_to_nibble_pixel_packer_top.sv
// Top level of the mono column to nibble pixel packer
//
// channel  dir  tdata                                 tuser / tlast
// req      in   [7:0] pixel_byte                      tuser: frame_start
// rsp      out  [10:0] display_addr, [16:11] data     tlast: last_write
//
// An even-column byte is taken and gives no beat.
// An odd-column byte gives eight rsp beats from the back-end row loop, one a cycle unless rsp stalls.
// A four-entry queue lets the front keep taking bytes while the back end streams writes.
// Reset clears position, even-column buffer, queue and output valid.
// A stalled rsp holds its beat; req stalls only while the queue is full.
`include "mono_column_to_nibble_pixel_packer_top_macros.svh"

module mono_column_to_nibble_pixel_packer_top #(
   parameter int PANEL_COLUMNS = 128,
   parameter int PANEL_ROWS    = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] pixel_byte
   input  logic                              req_tuser,   // [0] frame_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cnp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [10:0] display_addr, [16:11] display_data
   output logic                              rsp_tlast    // last_write
);

   localparam int ROW_STRIDE = PANEL_COLUMNS / 2;

   cnp_pkg::qstat_type          qstat;
   cnp_pkg::entry_type          push_entry, head_entry;
   logic                        push, pop;
   logic [cnp_pkg::ADDR_W-1:0]  rsp_addr;
   logic [cnp_pkg::DATA_W-1:0]  rsp_data;

   cnp_front #(
      .PANEL_COLUMNS (PANEL_COLUMNS),
      .PANEL_ROWS    (PANEL_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   cnp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .qstat      (qstat)
   );

   cnp_back #(
      .ROW_STRIDE (ROW_STRIDE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_addr   (rsp_addr),
      .rsp_data   (rsp_data),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {{cnp_pkg::RSP_PAD_W{1'b0}}, rsp_data, rsp_addr};

   `CNP_ASSERT_NEXT(a_row_run_contiguous, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && (rsp_tdata[10:0] == 11'($past(rsp_tdata[10:0]) + ROW_STRIDE)))
   `CNP_ASSERT_NOW(a_gap_bits_clear, clock, reset,
      rsp_tvalid,
      (rsp_tdata[14:13] == 2'b00) && (rsp_tdata[23:17] == 7'd0))
   `CNP_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule
